@@ rtl/wsl_pkg.sv @@
// ----------------------------------------------------------------------------
// wsl_pkg: shared types and constants of the station learning table
// Holds the request function codes, the sequencer states, the table entry
// layout and the 802.11 frame control constants.
// ----------------------------------------------------------------------------
package wsl_pkg;

  localparam int unsigned AddrWidth   = 48;
  localparam int unsigned FramesWidth = 16;
  localparam int unsigned GroupBit    = 40;

  localparam logic [11:0] MinHeaderBytes      = 12'd24;
  localparam logic [3:0]  ProbeRequestSubtype = 4'd4;
  localparam logic [1:0]  TypeManagement      = 2'd0;
  localparam logic [1:0]  TypeData            = 2'd2;

  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [AddrWidth-1:0]   addr;
    logic [FramesWidth-1:0] frames;
  } entry_t;

endpackage

@@ rtl/wsl_table.sv @@
// ----------------------------------------------------------------------------
// wsl_table: station table storage
// Single write port and one registered read port holding address and frame
// count of each learned station.
// ----------------------------------------------------------------------------
module wsl_table
  import wsl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned AW          = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wsl_seq.sv @@
// ----------------------------------------------------------------------------
// wsl_seq: request sequencer and shared address comparator
// Classifies each request, then walks the table once per address to learn,
// one entry per cycle, through a single 48-bit compare unit.
// ----------------------------------------------------------------------------
module wsl_seq
  import wsl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned AW          = 5,
  parameter int unsigned CW          = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [1:0]             func_i,
  input  logic                   is_misc_i,
  input  logic [11:0]            frame_length_i,
  input  logic [7:0]             control_low_i,
  input  logic [7:0]             control_high_i,
  input  logic [AddrWidth-1:0]   address_one_i,
  input  logic [AddrWidth-1:0]   address_two_i,
  input  logic [AddrWidth-1:0]   address_three_i,
  input  logic [4:0]             read_index_i,
  input  logic [AddrWidth-1:0]   bssid_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [CW-1:0]          station_total_o,
  output logic [AddrWidth-1:0]   entry_address_o,
  output logic [FramesWidth-1:0] entry_frames_o,
  output logic                   entry_valid_o,
  output logic [1:0]             addresses_noted_o,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output entry_t                 mem_wdata_o,
  output logic                   mem_re_o,
  output logic [AW-1:0]          mem_raddr_o,
  input  entry_t                 mem_rdata_i
);

  localparam int unsigned XW = (CW > 5) ? CW : 5;

  state_e state_q, state_d;

  func_e                  func_q;
  logic                   is_misc_q;
  logic [11:0]            length_q;
  logic [7:0]             ctl_low_q, ctl_high_q;
  logic [AddrWidth-1:0]   a1_q, a2_q, a3_q;
  logic [4:0]             rd_idx_q;

  logic [AddrWidth-1:0]   slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]             slot_en_q, slot_en_d;
  logic [AddrWidth-1:0]   cur_addr_q, cur_addr_d;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          pend_idx_q, pend_idx_d;
  logic [CW-1:0]          count_q, count_d;
  logic [1:0]             noted_q, noted_d;
  logic [AddrWidth-1:0]   e_addr_q, e_addr_d;
  logic [FramesWidth-1:0] e_frames_q, e_frames_d;
  logic                   e_valid_q, e_valid_d;

  logic                   hit, more, room, read_ok;
  logic [AddrWidth-1:0]   sel_addr;
  logic                   slot_frame_ignored, mgmt, data, to_ds, from_ds;
  logic                   a1_eq, a2_eq, a3_eq;

  // The one shared comparator: table entry against the address being learned.
  assign hit      = pend_q && (mem_rdata_i.addr == cur_addr_q);
  assign more     = ptr_q < count_q;
  assign room     = count_q < CW'(TABLE_DEPTH);
  assign read_ok  = XW'(rd_idx_q) < XW'(count_q);
  assign sel_addr = slot_en_q[0] ? slot0_q : slot1_q;

  assign slot_frame_ignored = is_misc_q || (length_q < MinHeaderBytes);
  assign mgmt    = ctl_low_q[3:2] == TypeManagement;
  assign data    = ctl_low_q[3:2] == TypeData;
  assign to_ds   = ctl_high_q[0];
  assign from_ds = ctl_high_q[1];
  assign a1_eq   = a1_q == bssid_i;
  assign a2_eq   = a2_q == bssid_i;
  assign a3_eq   = a3_q == bssid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (func_q)
          FUNC_FRAME: state_d = ST_LOAD;
          FUNC_READ:  state_d = ST_READ;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_LOAD: begin
        if (slot_en_q == 2'b00) begin
          state_d = ST_DONE;
        end else if (!sel_addr[GroupBit]) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || (!more && !pend_q)) state_d = ST_LOAD;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    slot0_d     = slot0_q;
    slot1_d     = slot1_q;
    slot_en_d   = slot_en_q;
    cur_addr_d  = cur_addr_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    count_d     = count_q;
    noted_d     = noted_q;
    e_addr_d    = e_addr_q;
    e_frames_d  = e_frames_q;
    e_valid_d   = e_valid_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pend_idx_q;
    mem_wdata_o = '{addr: cur_addr_q, frames: FramesWidth'(mem_rdata_i.frames + 1'b1)};
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[AW-1:0];
    unique case (state_q)
      ST_DECODE: begin
        noted_d     = 2'd0;
        e_addr_d    = '0;
        e_frames_d  = '0;
        e_valid_d   = 1'b0;
        slot0_d     = (data && from_ds && !to_ds) ? a1_q : a2_q;
        slot1_d     = a1_q;
        slot_en_d   = 2'b00;
        mem_raddr_o = AW'(rd_idx_q);
        unique case (func_q)
          FUNC_FRAME: begin
            if (!slot_frame_ignored) begin
              if (mgmt && ctl_low_q[7:4] == ProbeRequestSubtype) begin
                slot_en_d = 2'b01;
              end else if (mgmt) begin
                slot_en_d = a3_eq ? {!a1_eq, !a2_eq} : 2'b00;
              end else if (data && to_ds && !from_ds) begin
                slot_en_d = {1'b0, a1_eq};
              end else if (data && from_ds && !to_ds) begin
                slot_en_d = {1'b0, a2_eq};
              end
            end
          end
          FUNC_READ:  mem_re_o = 1'b1;
          FUNC_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      ST_LOAD: begin
        ptr_d  = '0;
        pend_d = 1'b0;
        cur_addr_d = sel_addr;
        if (slot_en_q[0]) begin
          slot_en_d[0] = 1'b0;
        end else begin
          slot_en_d[1] = 1'b0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // Matched entry: bump its count in place and stop the walk.
          mem_we_o = 1'b1;
          noted_d  = noted_q + 2'd1;
          pend_d   = 1'b0;
        end else if (more) begin
          mem_re_o   = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[AW-1:0];
          ptr_d      = ptr_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q && room) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = count_q[AW-1:0];
            mem_wdata_o = '{addr: cur_addr_q, frames: FramesWidth'(1)};
            count_d     = count_q + 1'b1;
            noted_d     = noted_q + 2'd1;
          end
        end
      end
      ST_READ: begin
        e_valid_d  = read_ok;
        e_addr_d   = read_ok ? mem_rdata_i.addr : '0;
        e_frames_d = read_ok ? mem_rdata_i.frames : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      func_q     <= func_e'(func_i);
      is_misc_q  <= is_misc_i;
      length_q   <= frame_length_i;
      ctl_low_q  <= control_low_i;
      ctl_high_q <= control_high_i;
      a1_q       <= address_one_i;
      a2_q       <= address_two_i;
      a3_q       <= address_three_i;
      rd_idx_q   <= read_index_i;
    end
    slot0_q    <= slot0_d;
    slot1_q    <= slot1_d;
    cur_addr_q <= cur_addr_d;
    pend_idx_q <= pend_idx_d;
    ptr_q      <= ptr_d;
    e_addr_q   <= e_addr_d;
    e_frames_q <= e_frames_d;
    e_valid_q  <= e_valid_d;
    noted_q    <= noted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      slot_en_q <= 2'b00;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      slot_en_q <= slot_en_d;
    end
  end

  assign busy_o            = state_q != ST_IDLE;
  assign done_o            = state_q == ST_DONE;
  assign station_total_o   = count_q;
  assign entry_address_o   = e_addr_q;
  assign entry_frames_o    = e_frames_q;
  assign entry_valid_o     = e_valid_q;
  assign addresses_noted_o = noted_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("station count exceeds table depth");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == ST_SCAN))
    else $error("table written outside the scan");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == ST_IDLE))
    else $error("result strobe longer than one cycle");

  a_start_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_DECODE))
    else $error("accepted request not decoded");

  a_insert_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && !hit) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insertion did not advance the count");

endmodule

@@ rtl/wlan_station_learning_table.sv @@
// ----------------------------------------------------------------------------
// wlan_station_learning_table: 802.11 station address learning table
// Classifies frame headers against the configured BSSID and learns unicast
// station addresses with a per-station frame count; also reads and clears.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   request   in         start_i while !busy  func, is_misc, frame_length,
//                                             control bytes, three addresses,
//                                             read_index
//   result    out        done_o, one cycle    station_total, entry_address,
//                                             entry_frames, entry_valid,
//                                             addresses_noted
//   config    in         cfg_we_i             target BSSID (cfg_wdata_i)
//
// A frame request walks the held stations once for each of its unicast
// addresses, reading one entry per cycle from the single read port and
// checking it with the one shared 48-bit comparator; the walk stops at a
// match, and a multicast address is not looked up. Read, clear and
// unused-function requests do not walk the table.
// Reset clears the station count, the sequencer and the BSSID register; table
// storage is not cleared, as only entries below the count are ever used.
// The receiver cannot stall: each result is shown on done_o for one cycle.
// ----------------------------------------------------------------------------
module wlan_station_learning_table
  import wsl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  input  logic                                 cfg_we_i,
  input  logic [AddrWidth-1:0]                 cfg_wdata_i,
  input  logic [1:0]                           func_i,
  input  logic                                 is_misc_i,
  input  logic [11:0]                          frame_length_i,
  input  logic [7:0]                           control_low_i,
  input  logic [7:0]                           control_high_i,
  input  logic [AddrWidth-1:0]                 address_one_i,
  input  logic [AddrWidth-1:0]                 address_two_i,
  input  logic [AddrWidth-1:0]                 address_three_i,
  input  logic [4:0]                           read_index_i,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     station_total_o,
  output logic [AddrWidth-1:0]                 entry_address_o,
  output logic [FramesWidth-1:0]               entry_frames_o,
  output logic                                 entry_valid_o,
  output logic [1:0]                           addresses_noted_o
);

  // Index width of the table and width of the station count, which must hold
  // the depth itself.
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // The BSSID filter register. Write it only while the block is idle, so the
  // sequencer may read it directly throughout a request; the block does not enforce it.
  logic [AddrWidth-1:0] bssid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bssid_q <= '0;
    end else if (cfg_we_i) begin
      bssid_q <= cfg_wdata_i;
    end
  end

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // The sequencer owns the station count and all control; it drives the
  // table's single write port and single read port.
  wsl_seq #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .func_i           (func_i),
    .is_misc_i        (is_misc_i),
    .frame_length_i   (frame_length_i),
    .control_low_i    (control_low_i),
    .control_high_i   (control_high_i),
    .address_one_i    (address_one_i),
    .address_two_i    (address_two_i),
    .address_three_i  (address_three_i),
    .read_index_i     (read_index_i),
    .bssid_i          (bssid_q),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .station_total_o  (station_total_o),
    .entry_address_o  (entry_address_o),
    .entry_frames_o   (entry_frames_o),
    .entry_valid_o    (entry_valid_o),
    .addresses_noted_o(addresses_noted_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  // Station storage: address and frame count side by side in one entry.
  wsl_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
